FILE: src/quaternion_unit_macros.svh
// assertion macros for the quaternion unit
`ifndef QUATERNION_UNIT_MACROS_SVH
`define QUATERNION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QU_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion unit check failed");
`define QU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quaternion unit check failed");
`else
`define QU_ASSERT_SAME(name, ante, cons)
`define QU_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: src/qu_pkg.sv
`timescale 1ns / 1ps
package qu_pkg;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_NORM = 2'd1,
    OP_MAT  = 2'd2,
    OP_AXIS = 2'd3
  } op_t;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_BITS    = 59;
  localparam int LANES       = 4;

  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [24:0] PI_360   = 25'sd9370165;
  localparam logic signed [27:0] DEG_180  = 28'sd11796480;
  localparam logic signed [27:0] DEG_360  = 28'sd23592960;
  localparam logic signed [27:0] DEG_720  = 28'sd47185920;
  localparam logic signed [39:0] ONE_Q28  = 40'sd268435456;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [3:0][31:0] a;
    logic [8:0][31:0] res;
    logic [63:0] sq_src;
    logic [33:0] sq_rem;
    logic [31:0] sq_root;
    logic [33:0] cx;
    logic [33:0] cy;
    logic [33:0] cz;
    logic        neg_cos;
  } mid_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [3:0][31:0] a;
    logic [8:0][31:0] res;
    logic        mzero;
    logic [3:0]  neg;
    logic [31:0] sn;
    logic [2:0][63:0] prod;
  } post_t;

  // four floored terms summed, then rounded to q.28
  function automatic logic signed [37:0] ham(input logic signed [63:0] t0,
                                             input logic signed [63:0] t1,
                                             input logic signed [63:0] t2,
                                             input logic signed [63:0] t3,
                                             input logic n1, input logic n2,
                                             input logic n3);
    logic signed [51:0] e0, e1, e2, e3, sum;
    e0 = 52'(t0 >>> 14);
    e1 = 52'(t1 >>> 14);
    e2 = 52'(t2 >>> 14);
    e3 = 52'(t3 >>> 14);
    if (n1) e1 = -e1;
    if (n2) e2 = -e2;
    if (n3) e3 = -e3;
    sum = e0 + e1 + e2 + e3;
    return 38'((sum + 52'sd8192) >>> 14);
  endfunction

  function automatic logic signed [36:0] mulq(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + 65'sd134217728;
    return 37'(t >>> 28);
  endfunction

endpackage

FILE: src/qu_div.sv
`timescale 1ns / 1ps
module qu_div import qu_pkg::*; (
  input  logic                            clk,
  input  logic [LANES-1:0][DIV_BITS-1:0]  num,
  input  logic [31:0]                     den,
  output logic [LANES-1:0][DIV_BITS-1:0]  quo
);

  logic [LANES-1:0][31:0]         rem_st [DIV_BITS];
  logic [LANES-1:0][DIV_BITS-1:0] num_st [DIV_BITS];
  logic [LANES-1:0][DIV_BITS-1:0] quo_st [DIV_BITS];
  logic [31:0]                    den_st [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    logic [LANES-1:0][31:0]         rem_in, rem_next;
    logic [LANES-1:0][DIV_BITS-1:0] num_in, num_next;
    logic [LANES-1:0][DIV_BITS-1:0] quo_in, quo_next;
    logic [LANES-1:0][32:0]         trial;
    logic [31:0]                    den_in;

    if (k == 0) begin : g_head
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_body
      assign rem_in = rem_st[k-1];
      assign num_in = num_st[k-1];
      assign quo_in = quo_st[k-1];
      assign den_in = den_st[k-1];
    end

    // one quotient bit per stage, restoring
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_in[l], num_in[l][DIV_BITS-1]};
        if (trial[l] >= {1'b0, den_in}) begin
          rem_next[l] = 32'(trial[l] - {1'b0, den_in});
          quo_next[l] = {quo_in[l][DIV_BITS-2:0], 1'b1};
        end else begin
          rem_next[l] = trial[l][31:0];
          quo_next[l] = {quo_in[l][DIV_BITS-2:0], 1'b0};
        end
        num_next[l] = {num_in[l][DIV_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_st[k] <= rem_next;
      num_st[k] <= num_next;
      quo_st[k] <= quo_next;
      den_st[k] <= den_in;
    end
  end

  assign quo = quo_st[DIV_BITS-1];

endmodule

FILE: src/quaternion_unit.sv
`timescale 1ns / 1ps
// Quaternion unit: Hamilton product, normalize, rotation matrix and axis-angle build in Q3.28.
// An item is taken when start is high and busy is low. Multiply, normalize and axis-angle
// items may follow one another every cycle; a matrix item gives four rows on consecutive
// cycles and holds busy high after it is taken, so the next item waits until busy falls.
// Every operation runs through the same pipeline: an input register, a product stage, a
// sum stage, a 32-stage square root (with the CORDIC stages beside it) and a 59-stage
// divider, so results appear in the order their items were taken. Results are marked by
// strobe for one cycle each; the receiver cannot stall them, and last marks the final
// result of an item.
`include "quaternion_unit_macros.svh"
module quaternion_unit import qu_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] a_w,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] b_w,
  input  logic signed [25:0] angle_deg,
  output logic               strobe,
  output logic signed [31:0] out0,
  output logic signed [31:0] out1,
  output logic signed [31:0] out2,
  output logic signed [31:0] out3,
  output logic [1:0]         row_index,
  output logic               last
);

  function automatic logic [31:0] sat(input logic signed [65:0] v);
    logic signed [65:0] hi, lo, c;
    hi = (66'sd1 <<< (DATA_WIDTH - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) c = hi;
    else if (v < lo) c = lo;
    else c = v;
    return c[31:0];
  endfunction

  logic       acc;
  logic [1:0] busy_cnt;

  assign acc  = start && !busy;
  assign busy = (busy_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= 2'd0;
    end else if (acc && opcode == OP_MAT) begin
      busy_cnt <= 2'd3;
    end else if (busy_cnt != 2'd0) begin
      busy_cnt <= busy_cnt - 2'd1;
    end
  end

  // input register
  logic             v1;
  op_t              op1;
  logic [3:0][31:0] a1, b1;
  logic signed [25:0] ang1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= acc;
    op1  <= op_t'(opcode);
    a1   <= {a_w, a_z, a_y, a_x};
    b1   <= {b_w, b_z, b_y, b_x};
    ang1 <= angle_deg;
  end

  // product stage
  word_t qx, qy, qz, qw, rx, ry, rz, rw;
  word_t pa [16];
  word_t pb [16];
  logic signed [27:0] af;
  logic               nc;

  assign qx = $signed(a1[0]);
  assign qy = $signed(a1[1]);
  assign qz = $signed(a1[2]);
  assign qw = $signed(a1[3]);
  assign rx = $signed(b1[0]);
  assign ry = $signed(b1[1]);
  assign rz = $signed(b1[2]);
  assign rw = $signed(b1[3]);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pa[i] = '0;
      pb[i] = '0;
    end
    unique case (op1)
      OP_MUL: begin
        pa[0]  = qw; pb[0]  = rx;
        pa[1]  = qx; pb[1]  = rw;
        pa[2]  = qy; pb[2]  = rz;
        pa[3]  = qz; pb[3]  = ry;
        pa[4]  = qw; pb[4]  = ry;
        pa[5]  = qx; pb[5]  = rz;
        pa[6]  = qy; pb[6]  = rw;
        pa[7]  = qz; pb[7]  = rx;
        pa[8]  = qw; pb[8]  = rz;
        pa[9]  = qx; pb[9]  = ry;
        pa[10] = qy; pb[10] = rx;
        pa[11] = qz; pb[11] = rw;
        pa[12] = qw; pb[12] = rw;
        pa[13] = qx; pb[13] = rx;
        pa[14] = qy; pb[14] = ry;
        pa[15] = qz; pb[15] = rz;
      end
      default: begin
        pa[0] = qx; pb[0] = qx;
        pa[1] = qx; pb[1] = qy;
        pa[2] = qx; pb[2] = qz;
        pa[3] = qx; pb[3] = qw;
        pa[4] = qy; pb[4] = qy;
        pa[5] = qy; pb[5] = qz;
        pa[6] = qy; pb[6] = qw;
        pa[7] = qz; pb[7] = qz;
        pa[8] = qz; pb[8] = qw;
        pa[9] = qw; pb[9] = qw;
      end
    endcase
  end

  // wrap into (-360,360], then fold into [-180,180]
  always_comb begin
    af = 28'(ang1);
    nc = 1'b0;
    if (af > DEG_360) af = af - DEG_720;
    if (af <= -DEG_360) af = af + DEG_720;
    if (af > DEG_180) begin
      af = DEG_360 - af;
      nc = 1'b1;
    end else if (af < -DEG_180) begin
      af = -DEG_360 - af;
      nc = 1'b1;
    end
  end

  logic               v2;
  op_t                op2;
  logic [3:0][31:0]   a2;
  logic signed [63:0] p2 [16];
  logic signed [27:0] angf2;
  logic               negc2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    op2   <= op1;
    a2    <= a1;
    angf2 <= af;
    negc2 <= nc;
    for (int i = 0; i < 16; i++) p2[i] <= pa[i] * pb[i];
  end

  // sum stage
  mid_t m_st [SQRT_STAGES+1];
  mid_t m0_next;
  logic signed [37:0] h0, h1, h2, h3;
  logic signed [36:0] xx, xy, xz, xw, yy, yz, yw, zz, zw;
  logic signed [52:0] rp;

  always_comb begin
    h0 = ham(p2[0], p2[1], p2[2], p2[3], 1'b0, 1'b0, 1'b1);
    h1 = ham(p2[4], p2[5], p2[6], p2[7], 1'b1, 1'b0, 1'b0);
    h2 = ham(p2[8], p2[9], p2[10], p2[11], 1'b0, 1'b1, 1'b0);
    h3 = ham(p2[12], p2[13], p2[14], p2[15], 1'b1, 1'b1, 1'b1);
    xx = mulq(p2[0]);
    xy = mulq(p2[1]);
    xz = mulq(p2[2]);
    xw = mulq(p2[3]);
    yy = mulq(p2[4]);
    yz = mulq(p2[5]);
    yw = mulq(p2[6]);
    zz = mulq(p2[7]);
    zw = mulq(p2[8]);
    rp = angf2 * PI_360;

    m0_next         = '0;
    m0_next.valid   = v2;
    m0_next.op      = op2;
    m0_next.a       = a2;
    m0_next.sq_src  = {2'b00, p2[0][63:2]} + {2'b00, p2[4][63:2]} +
                      {2'b00, p2[7][63:2]} + {2'b00, p2[9][63:2]};
    m0_next.cx      = CORDIC_K;
    m0_next.cz      = 34'((rp + 53'sd32768) >>> 16);
    m0_next.neg_cos = negc2;
    if (op2 == OP_MUL) begin
      m0_next.res[0] = sat(66'(h0));
      m0_next.res[1] = sat(66'(h1));
      m0_next.res[2] = sat(66'(h2));
      m0_next.res[3] = sat(66'(h3));
    end else begin
      m0_next.res[0] = sat(66'(ONE_Q28 - 40'sd2 * (40'(yy) + 40'(zz))));
      m0_next.res[1] = sat(66'(40'sd2 * (40'(xy) + 40'(zw))));
      m0_next.res[2] = sat(66'(40'sd2 * (40'(xz) - 40'(yw))));
      m0_next.res[3] = sat(66'(40'sd2 * (40'(xy) - 40'(zw))));
      m0_next.res[4] = sat(66'(ONE_Q28 - 40'sd2 * (40'(xx) + 40'(zz))));
      m0_next.res[5] = sat(66'(40'sd2 * (40'(yz) + 40'(xw))));
      m0_next.res[6] = sat(66'(40'sd2 * (40'(xz) + 40'(yw))));
      m0_next.res[7] = sat(66'(40'sd2 * (40'(yz) - 40'(xw))));
      m0_next.res[8] = sat(66'(ONE_Q28 - 40'sd2 * (40'(xx) + 40'(yy))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_st[0].valid <= 1'b0;
    else m_st[0] <= m0_next;
  end

  // square root, one root bit a stage; cordic rotations alongside
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_mid
    mid_t nxt;
    logic [35:0] rem_try, sub;
    logic signed [33:0] sx, sy, sz, dx, dy, at;

    always_comb begin
      nxt     = m_st[k];
      rem_try = {m_st[k].sq_rem, m_st[k].sq_src[63:62]};
      sub     = {2'b00, m_st[k].sq_root, 2'b01};
      nxt.sq_src = {m_st[k].sq_src[61:0], 2'b00};
      if (rem_try >= sub) begin
        nxt.sq_rem  = 34'(rem_try - sub);
        nxt.sq_root = {m_st[k].sq_root[30:0], 1'b1};
      end else begin
        nxt.sq_rem  = rem_try[33:0];
        nxt.sq_root = {m_st[k].sq_root[30:0], 1'b0};
      end
      sx = $signed(m_st[k].cx);
      sy = $signed(m_st[k].cy);
      sz = $signed(m_st[k].cz);
      dx = sy >>> k;
      dy = sx >>> k;
      at = $signed({2'b00, ATAN_Q30[k]});
      if (k < CORDIC_STAGES) begin
        if (!sz[33]) begin
          nxt.cx = sx - dx;
          nxt.cy = sy + dy;
          nxt.cz = sz - at;
        end else begin
          nxt.cx = sx + dx;
          nxt.cy = sy - dy;
          nxt.cz = sz + at;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) m_st[k+1].valid <= 1'b0;
      else m_st[k+1] <= nxt;
    end
  end

  // divider setup and axis-angle scaling
  mid_t                           ml;
  post_t                          p_st [DIV_BITS];
  post_t                          p0_next;
  logic [LANES-1:0][DIV_BITS-1:0] div_num, div_quo;
  logic [31:0]                    div_den;
  logic signed [32:0]             c33, mag;
  logic signed [31:0]             cs;

  assign ml      = m_st[SQRT_STAGES];
  assign div_den = ml.sq_root;

  always_comb begin
    p0_next       = '0;
    p0_next.valid = ml.valid;
    p0_next.op    = ml.op;
    p0_next.a     = ml.a;
    p0_next.res   = ml.res;
    p0_next.mzero = (ml.sq_root == 32'd0);
    c33 = '0;
    mag = '0;
    for (int j = 0; j < LANES; j++) begin
      c33 = 33'($signed(ml.a[j]));
      mag = c33[32] ? -c33 : c33;
      p0_next.neg[j] = c33[32];
      div_num[j] = 59'({mag, 27'd0}) + 59'(ml.sq_root >> 1);
    end
    cs = 32'(($signed(ml.cx) + 34'sd2) >>> 2);
    if (ml.neg_cos) cs = -cs;
    p0_next.sn = 32'(($signed(ml.cy) + 34'sd2) >>> 2);
    if (ml.op == OP_AXIS) p0_next.res[3] = sat(66'(cs));
  end

  qu_div u_div (
    .clk (clk),
    .num (div_num),
    .den (div_den),
    .quo (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) p_st[0].valid <= 1'b0;
    else p_st[0] <= p0_next;
  end

  for (genvar k = 1; k < DIV_BITS; k++) begin : g_post
    post_t nxt;

    always_comb begin
      nxt = p_st[k-1];
      if (k == 1) begin
        for (int j = 0; j < 3; j++) begin
          nxt.prod[j] = $signed(p_st[k-1].a[j]) * $signed(p_st[k-1].sn);
        end
      end
      if (k == 2 && p_st[k-1].op == OP_AXIS) begin
        for (int j = 0; j < 3; j++) begin
          nxt.res[j] = sat(66'(mulq($signed(p_st[k-1].prod[j]))));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) p_st[k].valid <= 1'b0;
      else p_st[k] <= nxt;
    end
  end

  // result select and row sequencing
  post_t              pf;
  logic [3:0][31:0]   row0, mrow;
  logic [5:0][31:0]   hold;
  logic               mat_on;
  logic [1:0]         mat_cnt;
  logic signed [65:0] qv;

  assign pf = p_st[DIV_BITS-1];

  always_comb begin
    row0 = '0;
    qv   = '0;
    unique case (pf.op)
      OP_MUL, OP_AXIS: row0 = pf.res[3:0];
      OP_MAT: begin
        row0[0] = pf.res[0];
        row0[1] = pf.res[1];
        row0[2] = pf.res[2];
      end
      OP_NORM: begin
        if (pf.mzero) begin
          row0 = pf.a;
        end else begin
          for (int j = 0; j < LANES; j++) begin
            qv = $signed({7'd0, div_quo[j]});
            row0[j] = sat(pf.neg[j] ? -qv : qv);
          end
        end
      end
    endcase
  end

  always_comb begin
    mrow = '0;
    unique case (mat_cnt)
      2'd1: mrow[2:0] = hold[2:0];
      2'd2: mrow[2:0] = hold[5:3];
      default: mrow[3] = sat(66'sd268435456);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe  <= 1'b0;
      mat_on  <= 1'b0;
      mat_cnt <= 2'd0;
    end else begin
      priority if (pf.valid) begin
        strobe    <= 1'b1;
        out0      <= $signed(row0[0]);
        out1      <= $signed(row0[1]);
        out2      <= $signed(row0[2]);
        out3      <= $signed(row0[3]);
        row_index <= 2'd0;
        last      <= (pf.op != OP_MAT);
        mat_on    <= (pf.op == OP_MAT);
        mat_cnt   <= 2'd1;
        hold      <= pf.res[8:3];
      end else if (mat_on) begin
        strobe    <= 1'b1;
        out0      <= $signed(mrow[0]);
        out1      <= $signed(mrow[1]);
        out2      <= $signed(mrow[2]);
        out3      <= $signed(mrow[3]);
        row_index <= mat_cnt;
        last      <= (mat_cnt == 2'd3);
        mat_on    <= (mat_cnt != 2'd3);
        mat_cnt   <= mat_cnt + 2'd1;
      end else begin
        strobe <= 1'b0;
      end
    end
  end

  `QU_ASSERT_NEXT(a_mat_holds_off, (acc && opcode == OP_MAT), busy)
  `QU_ASSERT_SAME(a_no_row_overlap, pf.valid, !mat_on)
  `QU_ASSERT_SAME(a_rows_contiguous, (strobe && row_index != 2'd0), $past(strobe))
  `QU_ASSERT_SAME(a_last_row, (strobe && row_index == 2'd3), last)

endmodule
